[src/cse_pkg.sv]
package cse_pkg;

  localparam int MAX_ITEMS   = 16;
  localparam int VALUE_BITS  = 4;
  localparam int VALUE_COUNT = 1 << VALUE_BITS;
  localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // one access to the count table per cycle: increment or decrement at addr
  typedef struct packed {
    logic   inc;
    logic   dec;
    value_t addr;
  } tbl_op_t;

endpackage

[src/cse_count_table.sv]
module cse_count_table (
  input  logic             clk,
  input  logic             rst,
  input  cse_pkg::tbl_op_t op,
  output cse_pkg::cnt_t    count
);
  import cse_pkg::*;

  cnt_t   table_q [VALUE_COUNT];
  cnt_t   sum;

  // shared unit: one adder for both histogram build and emission countdown
  assign count = table_q[op.addr];
  assign sum   = op.inc ? cnt_t'(count + cnt_t'(1)) : cnt_t'(count - cnt_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VALUE_COUNT; i++) begin
        table_q[i] <= '0;
      end
    end else if (op.inc || op.dec) begin
      table_q[op.addr] <= sum;
    end
  end

endmodule

[src/counting_sort_engine.sv]
// Counting sort of small unsigned values. Items are taken one per cycle
// while busy is low; the item with set_end high, or the one that brings the
// set to MAX_ITEMS values, closes the set and raises busy. The block then
// walks the value range from zero upward through its count table; each step
// puts the current value out, if its count is nonzero, or moves to the next
// entry. Each value present is put out once per occurrence with done high
// for one cycle, and the last one carries final_out. The busy phase of a set
// of n values holds its n results plus one scan step per value below the
// largest, serialised by the single count table port. Results cannot be held
// off; the receiver must take each one in the cycle done is high. The count
// table is emptied by the emission itself, so no clearing pass is needed.
module counting_sort_engine (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [3:0] sample_value,
  input  logic set_end,
  output logic done,
  output logic [3:0] sorted_value,
  output logic final_out
);
  import cse_pkg::*;

  typedef enum logic {LOAD, EMIT} state_t;

  state_t  state;
  cnt_t    items_held;
  cnt_t    remaining;
  value_t  scan;
  tbl_op_t op;
  cnt_t    count;
  logic    accept;
  logic    closing;

  assign busy    = (state == EMIT);
  assign accept  = start && (state == LOAD);
  assign closing = set_end || (items_held == cnt_t'(MAX_ITEMS - 1));

  always_comb begin
    op.inc  = 1'b0;
    op.dec  = 1'b0;
    op.addr = scan;
    if (state == LOAD) begin
      op.addr = sample_value[VALUE_BITS-1:0];
      op.inc  = accept;
    end else begin
      op.dec  = (count != '0);
    end
  end

  cse_count_table u_table (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .count (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LOAD;
      items_held <= '0;
      remaining  <= '0;
      scan       <= '0;
      done       <= 1'b0;
      final_out  <= 1'b0;
    end else begin
      done      <= 1'b0;
      final_out <= 1'b0;
      case (state)
        LOAD: begin
          if (accept) begin
            if (closing) begin
              remaining  <= cnt_t'(items_held + cnt_t'(1));
              items_held <= '0;
              scan       <= '0;
              state      <= EMIT;
            end else begin
              items_held <= cnt_t'(items_held + cnt_t'(1));
            end
          end
        end
        EMIT: begin
          if (count != '0) begin
            done         <= 1'b1;
            sorted_value <= 4'(scan);
            final_out    <= (remaining == cnt_t'(1));
            remaining    <= cnt_t'(remaining - cnt_t'(1));
            if (remaining == cnt_t'(1)) begin
              state <= LOAD;
            end
          end else begin
            scan <= value_t'(scan + value_t'(1));
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

endmodule

[src/cse_checker.sv]
module cse_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic final_out
);

  a_final_has_strobe: assert property (@(posedge clk) disable iff (rst)
    final_out |-> done)
    else $error("final_out without done");

  a_mid_set_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !final_out) |-> busy)
    else $error("set ended before its final item");

  a_gap_after_final: assert property (@(posedge clk) disable iff (rst)
    (done && final_out) |=> !done)
    else $error("result after final item");

  a_accept_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result right after an accepted item");

  a_busy_ends_on_final: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done && final_out))
    else $error("busy dropped without final item");

endmodule

bind counting_sort_engine cse_checker u_cse_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .final_out (final_out)
);
